### sv/mmwg_pkg.sv
// Shared constants, types and functions of the multi-mode waveform generator.
package mmwg_pkg;

    localparam int MAX_PERIOD  = 4096;
    localparam int SINE_DEPTH  = 1024;
    localparam int SINE_AW     = $clog2(SINE_DEPTH);
    localparam int IDX_W       = 12;
    localparam int PER_W       = 13;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int NUM_W       = 30;
    localparam int DEN_W       = 14;
    localparam int DIV_STEPS   = NUM_W / 2;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    localparam logic [CFG_IDX_W-1:0] CFG_WAVE_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAGNITUDE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE_FRAC  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SUB_PERIOD = 3'd5;

    localparam logic [2:0] MODE_SINE   = 3'd1;
    localparam logic [2:0] MODE_TRI    = 3'd2;
    localparam logic [2:0] MODE_SQUARE = 3'd3;

    localparam logic [63:0] SIN_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                           64'd110, 64'd156, 64'd210};
    localparam logic [63:0] COS_DIV [7] = '{64'd2, 64'd12, 64'd30, 64'd56,
                                           64'd90, 64'd132, 64'd182};

    typedef logic signed [15:0] t_sine_tab [SINE_DEPTH];

    typedef struct packed {
        logic accept;
        logic rise_load;
        logic setup;
        logic mac_load;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
    } t_dp_sts;

    function automatic logic signed [15:0] sine_entry(input logic [63:0] k);
        logic [63:0]        n;
        logic [63:0]        q;
        logic [63:0]        rem;
        logic [63:0]        f;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] s;
        logic signed [63:0] c;
        logic signed [63:0] v;
        logic [63:0]        r;
        n   = 64'd4 * k;
        q   = n / SINE_DEPTH;
        rem = n % SINE_DEPTH;
        f   = (rem << 30) / SINE_DEPTH;
        x   = (f * HALF_PI_Q30) >> 30;
        x2  = (x * x) >> 30;
        s   = signed'(x);
        c   = 64'sd1 <<< 30;
        term = x;
        for (int t = 0; t < 7; t++) begin
            term = ((term * x2) >> 30) / SIN_DIV[t];
            if (t % 2 == 0) begin
                s = s - signed'(term);
            end else begin
                s = s + signed'(term);
            end
        end
        term = 64'd1 << 30;
        for (int t = 0; t < 7; t++) begin
            term = ((term * x2) >> 30) / COS_DIV[t];
            if (t % 2 == 0) begin
                c = c - signed'(term);
            end else begin
                c = c + signed'(term);
            end
        end
        v = (q == 64'd0 || q == 64'd2) ? s : c;
        if (v < 0) begin
            v = 0;
        end
        r = (unsigned'(v) + 64'd16384) >> 15;
        if (r > 64'd32767) begin
            r = 64'd32767;
        end
        return (q >= 64'd2) ? -signed'(16'(r)) : signed'(16'(r));
    endfunction

    function automatic t_sine_tab sine_table();
        t_sine_tab tab;
        for (int k = 0; k < SINE_DEPTH; k++) begin
            tab[k] = sine_entry(64'(k));
        end
        return tab;
    endfunction

    function automatic logic [15:0] sat16(input logic signed [19:0] v);
        logic [15:0] res;
        if (v > 20'sd32767) begin
            res = 16'h7fff;
        end else if (v < -20'sd32768) begin
            res = 16'h8000;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

endpackage

### sv/mmwg_sine_rom.sv
// Full-period sine table, Q1.15, registered read.
module mmwg_sine_rom (
    input  logic                           i_clk,
    input  logic [mmwg_pkg::SINE_AW-1:0]   i_addr,
    output logic signed [15:0]             o_data
);
    import mmwg_pkg::*;

    localparam t_sine_tab ROM_TAB = sine_table();

    logic signed [15:0] r_data;

    always_ff @(posedge i_clk) begin
        r_data <= ROM_TAB[i_addr];
    end

    assign o_data = r_data;

endmodule

### sv/mmwg_divider.sv
// Restoring divider, two quotient bits per cycle.
module mmwg_divider (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [mmwg_pkg::NUM_W-1:0]   i_num,
    input  logic [mmwg_pkg::DEN_W-1:0]   i_den,
    output logic                         o_done,
    output logic [mmwg_pkg::NUM_W-1:0]   o_quot,
    output logic [mmwg_pkg::DEN_W-1:0]   o_rem
);
    import mmwg_pkg::*;

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0]     r_num;
    logic [DEN_W-1:0]     r_den;
    logic [DEN_W-1:0]     r_rem;

    logic [DEN_W:0]   s1;
    logic [DEN_W:0]   s2;
    logic             ge1;
    logic             ge2;
    logic [DEN_W-1:0] rem1;
    logic [DEN_W-1:0] rem2;

    always_comb begin
        s1   = {r_rem, r_num[NUM_W-1]};
        ge1  = s1 >= {1'b0, r_den};
        rem1 = ge1 ? DEN_W'(s1 - {1'b0, r_den}) : s1[DEN_W-1:0];
        s2   = {rem1, r_num[NUM_W-2]};
        ge2  = s2 >= {1'b0, r_den};
        rem2 = ge2 ? DEN_W'(s2 - {1'b0, r_den}) : s2[DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CNT_W'(DIV_STEPS - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-3:0], ge1, ge2};
            r_rem <= rem2;
        end
    end

    assign o_done = r_busy && (r_cnt == '0);
    assign o_quot = r_num;
    assign o_rem  = r_rem;

endmodule

### sv/mmwg_ctrl.sv
// Sequencing state machine and output word handshake.
module mmwg_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output mmwg_pkg::t_dp_cmd o_cmd,
    input  mmwg_pkg::t_dp_sts i_sts
);
    import mmwg_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_RISE  = 7'b0000010,
        S_SETUP = 7'b0000100,
        S_DIV   = 7'b0001000,
        S_ROM   = 7'b0010000,
        S_MAC   = 7'b0100000,
        S_FIN   = 7'b1000000
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_out_valid;
    t_dp_cmd cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.accept = 1'b1;
                    n_state    = S_RISE;
                end
            end
            S_RISE: begin
                cmd.rise_load = 1'b1;
                n_state       = S_SETUP;
            end
            S_SETUP: begin
                cmd.setup = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_ROM;
                end
            end
            S_ROM: begin
                n_state = S_MAC;
            end
            S_MAC: begin
                cmd.mac_load = 1'b1;
                n_state      = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

### sv/mmwg_datapath.sv
// Config registers, sample index, ramp, sine and square arithmetic and output register.
module mmwg_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mmwg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mmwg_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                              i_restart,
    input  mmwg_pkg::t_dp_cmd                 i_cmd,
    output mmwg_pkg::t_dp_sts                 o_sts,
    output logic signed [15:0]                o_sample_value,
    output logic [mmwg_pkg::IDX_W-1:0]        o_sample_index,
    output logic                              o_period_last
);
    import mmwg_pkg::*;

    logic [2:0]       r_wave_mode;
    logic [14:0]      r_mag;
    logic [15:0]      r_off;
    logic [PER_W-1:0] r_period;
    logic [7:0]       r_rise_frac;
    logic [PER_W-1:0] r_sub;

    logic [IDX_W-1:0] r_phase;
    logic [IDX_W-1:0] r_idx;
    logic [PER_W-1:0] r_rise;
    logic             r_den_zero;
    logic signed [31:0] r_acc;

    logic signed [15:0] r_sample_value;
    logic [IDX_W-1:0]   r_sample_index;
    logic               r_period_last;

    logic [PER_W-1:0] p_eff;
    logic [PER_W-1:0] s_eff;
    logic [PER_W-1:0] idx13;
    logic             tri_up;
    logic [PER_W-1:0] num_sel;
    logic [PER_W-1:0] den_sel;
    logic [27:0]      tri_prod;
    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    logic             div_done;
    logic [NUM_W-1:0] quot;
    logic [DEN_W-1:0] rem;
    logic [SINE_AW-1:0] rom_addr;
    logic signed [15:0] rom_data;

    logic signed [32:0] sine_sum;
    logic signed [19:0] off20;
    logic signed [19:0] mag20;
    logic [16:0]        ramp;
    logic signed [19:0] val;
    logic               last;

    always_comb begin
        if (r_period == '0) begin
            p_eff = PER_W'(1);
        end else if (r_period > PER_W'(MAX_PERIOD)) begin
            p_eff = PER_W'(MAX_PERIOD);
        end else begin
            p_eff = r_period;
        end
        s_eff = (r_sub == '0) ? PER_W'(1) : r_sub;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_mode <= '0;
            r_mag       <= '0;
            r_off       <= '0;
            r_period    <= PER_W'(480);
            r_rise_frac <= 8'd205;
            r_sub       <= PER_W'(4);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WAVE_MODE:  r_wave_mode <= i_cfg_wdata[2:0];
                CFG_MAGNITUDE:  r_mag       <= i_cfg_wdata[14:0];
                CFG_OFFSET:     r_off       <= i_cfg_wdata;
                CFG_PERIOD:     r_period    <= i_cfg_wdata[PER_W-1:0];
                CFG_RISE_FRAC:  r_rise_frac <= i_cfg_wdata[7:0];
                CFG_SUB_PERIOD: r_sub       <= i_cfg_wdata[PER_W-1:0];
                default: ;
            endcase
        end
    end

    // divider operands per mode; triangle operands: ramp = (4*M*num + den) / (2*den)
    always_comb begin
        idx13    = {1'b0, r_idx};
        tri_up   = idx13 <= r_rise;
        num_sel  = tri_up ? idx13 : PER_W'(p_eff - idx13);
        den_sel  = tri_up ? r_rise : PER_W'(p_eff - r_rise);
        tri_prod = 28'(r_mag) * 28'(num_sel);
        case (r_wave_mode)
            MODE_SINE: begin
                div_num = NUM_W'(r_idx) * NUM_W'(SINE_DEPTH);
                div_den = DEN_W'(p_eff);
            end
            MODE_TRI: begin
                div_num = NUM_W'({tri_prod, 2'b00}) + NUM_W'(den_sel);
                div_den = {den_sel, 1'b0};
            end
            MODE_SQUARE: begin
                div_num = NUM_W'(r_idx);
                div_den = DEN_W'(s_eff);
            end
            default: begin
                div_num = '0;
                div_den = DEN_W'(1);
            end
        endcase
    end

    mmwg_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.setup),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (quot),
        .o_rem   (rem)
    );

    assign rom_addr = (quot >= NUM_W'(SINE_DEPTH)) ? SINE_AW'(SINE_DEPTH - 1)
                                                    : quot[SINE_AW-1:0];

    mmwg_sine_rom u_rom (
        .i_clk  (i_clk),
        .i_addr (rom_addr),
        .o_data (rom_data)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_idx <= (i_restart || ({1'b0, r_phase} >= p_eff)) ? '0 : r_phase;
        end
        if (i_cmd.rise_load) begin
            r_rise <= PER_W'((21'(p_eff) * 21'(r_rise_frac)) >> 8);
        end
        if (i_cmd.setup) begin
            r_den_zero <= (den_sel == '0);
        end
        if (i_cmd.mac_load) begin
            r_acc <= signed'({1'b0, r_mag}) * rom_data;
        end
    end

    always_comb begin
        sine_sum = {r_acc[31], r_acc} + {{2{r_off[15]}}, r_off, 15'd0} + 33'sd16384;
        off20    = signed'({{4{r_off[15]}}, r_off});
        mag20    = signed'({5'd0, r_mag});
        ramp     = r_den_zero ? {1'b0, r_mag, 1'b0} : quot[16:0];
        case (r_wave_mode)
            MODE_SINE: begin
                val = 20'(signed'(sine_sum[32:15]));
            end
            MODE_TRI: begin
                val = signed'({3'd0, ramp}) - mag20 + off20;
            end
            MODE_SQUARE: begin
                val = (rem >= DEN_W'(s_eff >> 1)) ? off20 + mag20 : off20 - mag20;
            end
            default: begin
                val = '0;
            end
        endcase
        last = (idx13 == PER_W'(p_eff - 1'b1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (i_cmd.out_load) begin
            r_phase <= last ? '0 : IDX_W'(r_idx + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_sample_value <= signed'(sat16(val));
            r_sample_index <= r_idx;
            r_period_last  <= last;
        end
    end

    assign o_sts.div_done = div_done;
    assign o_sample_value = r_sample_value;
    assign o_sample_index = r_sample_index;
    assign o_period_last  = r_period_last;

endmodule

### sv/multi_mode_waveform_generator_top.sv
// Top level of the multi-mode waveform generator.
//
//   channel  direction  handshake                  payload
//   in       sink       i_in_valid / o_in_stall    i_restart
//   out      source     o_out_valid / i_out_stall  o_sample_value, o_sample_index,
//                                                  o_period_last
//   cfg      sink       i_cfg_we                   i_cfg_index, i_cfg_wdata
//
// One word in, one word out. From acceptance to the next acceptance a word passes
// through rise multiply, operand setup, the radix-4 restoring divider shared by all
// modes, sine table read, scaling multiply and final sum; no new word is taken before.
// Reset is synchronous; the sine table is constant and needs no fill.
// A stalled output holds in its register while the next input word is taken.
module multi_mode_waveform_generator_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mmwg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mmwg_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_restart,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [15:0]                o_sample_value,
    output logic [mmwg_pkg::IDX_W-1:0]        o_sample_index,
    output logic                              o_period_last
);
    import mmwg_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    mmwg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    mmwg_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_restart      (i_restart),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_sample_value (o_sample_value),
        .o_sample_index (o_sample_index),
        .o_period_last  (o_period_last)
    );

endmodule
